>>> rtl/core/pdz_pkg.sv
// ============================================================================
// pdz_pkg
// Shared types and constants for the perspective dot plotter: controller
// states, controller-to-datapath commands, datapath status, register indexes.
// ============================================================================
package pdz_pkg;

    // Operand widths fixed by the item and register formats
    localparam int COORD_W     = 16;   // side, forward, point_height
    localparam int COLOR_W     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int PLANE_W     = 15;
    localparam int PIX_X_W     = 9;
    localparam int PIX_Y_W     = 8;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 32;
    localparam int DEPTH_W     = 16;
    localparam logic [DEPTH_W-1:0] DEPTH_FARTHEST = 16'hFFFF;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COS_PITCH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_PITCH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_PLANE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_PLANE  = 3'd4;

    // Register reset values
    localparam logic signed [15:0] COS_PITCH_RST  = 16'sd14378;
    localparam logic signed [15:0] SIN_PITCH_RST  = -16'sd7855;
    localparam logic signed [15:0] CAM_HEIGHT_RST = 16'sd5120;
    localparam logic [PLANE_W-1:0] NEAR_PLANE_RST = 15'd256;
    localparam logic [PLANE_W-1:0] FAR_PLANE_RST  = 15'd25600;

    // Item kinds
    localparam logic OP_PLOT  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Shared multiplier operand selection
    typedef enum logic [2:0] {
        MS_H_COS,
        MS_F_SIN,
        MS_H_SIN,
        MS_F_COS,
        MS_X_NUM,
        MS_Y_NUM,
        MS_ADDR
    } mul_sel_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_MUL4,
        ST_CHECK,
        ST_DIVX0,
        ST_DIVX,
        ST_XCHECK,
        ST_DIVY0,
        ST_DIVY,
        ST_YCHECK,
        ST_ADDR0,
        ST_ADDR1,
        ST_READ,
        ST_EMIT
    } state_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        logic     load_in;
        logic     acc_load;
        logic     up_load;
        logic     depth_load;
        logic     div_start;
        logic     div_y;
        logic     div_step;
        logic     px_load;
        logic     py_load;
        logic     addr_load;
        logic     mem_read;
        logic     emit;
        logic     clear_write;
    } dp_cmd_t;

    typedef struct packed {
        logic depth_ok;
        logic div_done;
        logic coord_ok;
        logic hit;
        logic clear_last;
        logic out_free;
    } dp_status_t;

endpackage

>>> rtl/core/pdz_ctrl.sv
// ============================================================================
// pdz_ctrl
// Sequencer for the plotter: clearing sweep, the multiply steps of the
// rotation, both projection divides, the store lookup and the pixel emit.
// ============================================================================
module pdz_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic                in_op,
    output logic                in_ready,
    input  pdz_pkg::dp_status_t status,
    output pdz_pkg::dp_cmd_t    cmd
);
    import pdz_pkg::*;

    state_t state_reg, state_next;

    // Hold state; reset starts with a sweep of the depth store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (status.clear_last) state_next = ST_IDLE;
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = (in_op == OP_CLEAR) ? ST_CLEAR : ST_MUL0;
                end
            end
            ST_MUL0:   state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_MUL3;
            ST_MUL3:   state_next = ST_MUL4;
            ST_MUL4:   state_next = ST_CHECK;
            ST_CHECK:  state_next = status.depth_ok ? ST_DIVX0 : ST_IDLE;
            ST_DIVX0:  state_next = ST_DIVX;
            ST_DIVX:   if (status.div_done) state_next = ST_XCHECK;
            ST_XCHECK: state_next = status.coord_ok ? ST_DIVY0 : ST_IDLE;
            ST_DIVY0:  state_next = ST_DIVY;
            ST_DIVY:   if (status.div_done) state_next = ST_YCHECK;
            ST_YCHECK: state_next = status.coord_ok ? ST_ADDR0 : ST_IDLE;
            ST_ADDR0:  state_next = ST_ADDR1;
            ST_ADDR1:  state_next = ST_READ;
            ST_READ:   state_next = ST_EMIT;
            ST_EMIT: begin
                if (!status.hit || status.out_free) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd      = '0;
        cmd.mul_sel = MS_H_COS;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:  cmd.clear_write = 1'b1;
            ST_IDLE: begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_MUL0:   cmd.mul_sel = MS_H_COS;
            ST_MUL1: begin
                cmd.mul_sel  = MS_F_SIN;
                cmd.acc_load = 1'b1;
            end
            ST_MUL2: begin
                cmd.mul_sel = MS_H_SIN;
                cmd.up_load = 1'b1;
            end
            ST_MUL3: begin
                cmd.mul_sel  = MS_F_COS;
                cmd.acc_load = 1'b1;
            end
            ST_MUL4:   cmd.depth_load = 1'b1;
            ST_CHECK:  cmd.mul_sel = MS_X_NUM;
            ST_DIVX0:  cmd.div_start = 1'b1;
            ST_DIVX:   cmd.div_step = !status.div_done;
            ST_XCHECK: begin
                cmd.mul_sel = MS_Y_NUM;
                cmd.px_load = 1'b1;
            end
            ST_DIVY0: begin
                cmd.div_start = 1'b1;
                cmd.div_y     = 1'b1;
            end
            ST_DIVY:   cmd.div_step = !status.div_done;
            ST_YCHECK: cmd.py_load = 1'b1;
            ST_ADDR0:  cmd.mul_sel = MS_ADDR;
            ST_ADDR1:  cmd.addr_load = 1'b1;
            ST_READ:   cmd.mem_read = 1'b1;
            ST_EMIT:   cmd.emit = status.hit && status.out_free;
            default:   cmd.mul_sel = MS_H_COS;
        endcase
    end

endmodule

>>> rtl/core/pdz_datapath.sv
// ============================================================================
// pdz_datapath
// Registers, shared multiplier, serial divider, depth store and output
// register of the plotter. Acts on commands from the controller.
// ============================================================================
module pdz_datapath #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  pdz_pkg::dp_cmd_t                      cmd,
    output pdz_pkg::dp_status_t                   status,
    input  logic [pdz_pkg::S_TDATA_W-1:0]         in_data,
    input  logic                                  cfg_write,
    input  logic [pdz_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pdz_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [pdz_pkg::M_TDATA_W-1:0]         out_data
);
    import pdz_pkg::*;

    localparam int STORE_N = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W  = $clog2(STORE_N);
    localparam int XC_W    = $clog2(SCREEN_WIDTH);
    localparam int YC_W    = $clog2(SCREEN_HEIGHT);
    localparam int A_W     = 20;             // largest multiplier operand A
    localparam int B_W     = 17;             // largest multiplier operand B
    localparam int P_W     = A_W + B_W;
    localparam int UP_W    = 19;
    localparam int DF_W    = P_W + 1 - 14;   // depth before range check
    localparam int NUM_W   = 32;
    localparam int DEN_W   = 16;
    localparam int CNT_W   = $clog2(NUM_W + 1);
    localparam logic [B_W-1:0]   W_B     = B_W'(SCREEN_WIDTH);
    localparam logic [B_W-1:0]   H_B     = B_W'(SCREEN_HEIGHT);
    localparam logic [NUM_W-1:0] W_LIM   = NUM_W'(SCREEN_WIDTH);
    localparam logic [NUM_W-1:0] H_LIM   = NUM_W'(SCREEN_HEIGHT);
    localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(STORE_N - 1);

    // Configuration registers
    logic signed [15:0]  cos_reg, sin_reg, cam_reg;
    logic [PLANE_W-1:0]  near_reg, far_reg;

    // Write configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_reg  <= COS_PITCH_RST;
            sin_reg  <= SIN_PITCH_RST;
            cam_reg  <= CAM_HEIGHT_RST;
            near_reg <= NEAR_PLANE_RST;
            far_reg  <= FAR_PLANE_RST;
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_COS_PITCH:  cos_reg  <= cfg_data;
                CFG_SIN_PITCH:  sin_reg  <= cfg_data;
                CFG_CAM_HEIGHT: cam_reg  <= cfg_data;
                CFG_NEAR_PLANE: near_reg <= cfg_data[PLANE_W-1:0];
                CFG_FAR_PLANE:  far_reg  <= cfg_data[PLANE_W-1:0];
                default: ;
            endcase
        end
    end

    // Item registers
    logic signed [COORD_W-1:0] side_reg, fwd_reg;
    logic signed [COORD_W:0]   h_reg;
    logic [COLOR_W-1:0]        color_reg;

    // Capture item; height relative to camera is exact in 17 bits
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            side_reg  <= in_data[15:0];
            fwd_reg   <= in_data[31:16];
            h_reg     <= {in_data[47], in_data[47:32]} - {cam_reg[15], cam_reg};
            color_reg <= in_data[55:48];
        end
    end

    // Shared multiplier
    logic signed [P_W-1:0]   prod_reg, acc_reg;
    logic signed [UP_W-1:0]  up_reg;
    logic signed [DF_W-1:0]  dfull_reg;
    logic signed [A_W-1:0]   mul_a;
    logic signed [B_W-1:0]   mul_b;
    logic [PLANE_W-1:0]      depth;
    logic [XC_W-1:0]         px_reg;
    logic [YC_W-1:0]         py_reg;

    assign depth = dfull_reg[PLANE_W-1:0];

    // Select multiplier operands
    always_comb begin
        mul_a = A_W'(h_reg);
        mul_b = B_W'(cos_reg);
        unique case (cmd.mul_sel)
            MS_H_COS: begin mul_a = A_W'(h_reg);   mul_b = B_W'(cos_reg); end
            MS_F_SIN: begin mul_a = A_W'(fwd_reg); mul_b = B_W'(sin_reg); end
            MS_H_SIN: begin mul_a = A_W'(h_reg);   mul_b = B_W'(sin_reg); end
            MS_F_COS: begin mul_a = A_W'(fwd_reg); mul_b = B_W'(cos_reg); end
            MS_X_NUM: begin
                mul_a = A_W'($signed({1'b0, depth})) + A_W'(side_reg);
                mul_b = W_B;
            end
            MS_Y_NUM: begin
                mul_a = A_W'($signed({1'b0, depth})) - A_W'(up_reg);
                mul_b = H_B;
            end
            MS_ADDR: begin
                mul_a = A_W'($signed({1'b0, py_reg}));
                mul_b = W_B;
            end
            default: ;
        endcase
    end

    // Combine products; floor shift by 14 for the Q2.14 factors
    logic signed [P_W:0] diff, sum;
    assign diff = {acc_reg[P_W-1], acc_reg} - {prod_reg[P_W-1], prod_reg};
    assign sum  = {acc_reg[P_W-1], acc_reg} + {prod_reg[P_W-1], prod_reg};

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (cmd.acc_load)   acc_reg   <= prod_reg;
        if (cmd.up_load)    up_reg    <= diff[14 +: UP_W];
        if (cmd.depth_load) dfull_reg <= sum[P_W:14];
    end

    assign status.depth_ok = (dfull_reg > 0)
                          && (dfull_reg >= $signed({1'b0, near_reg}))
                          && (dfull_reg <= $signed({1'b0, far_reg}));

    // Serial restoring divider: magnitude of numerator by 2*depth
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W:0]   rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg, divy_reg;
    logic [P_W-1:0]   mag;
    logic [DEN_W:0]   shifted, trial;

    assign mag     = prod_reg[P_W-1] ? P_W'(-prod_reg) : P_W'(prod_reg);
    assign shifted = {rem_reg[DEN_W-1:0], num_reg[NUM_W-1]};
    assign trial   = shifted - {1'b0, depth, 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.div_start) begin
            cnt_reg <= CNT_W'(NUM_W);
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            num_reg  <= mag[NUM_W-1:0];
            rem_reg  <= '0;
            neg_reg  <= prod_reg[P_W-1];
            divy_reg <= cmd.div_y;
        end else if (cmd.div_step) begin
            if (!trial[DEN_W]) begin
                rem_reg <= trial;
                num_reg <= {num_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted;
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    // Floor of a negative quotient is negative, so any negative numerator misses
    assign status.div_done = (cnt_reg == '0);
    assign status.coord_ok = !neg_reg && (num_reg < (divy_reg ? H_LIM : W_LIM));

    // Pixel and store address
    logic [ADDR_W-1:0] addr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.px_load)   px_reg   <= num_reg[XC_W-1:0];
        if (cmd.py_load)   py_reg   <= num_reg[YC_W-1:0];
        if (cmd.addr_load) addr_reg <= prod_reg[ADDR_W-1:0] + ADDR_W'(px_reg);
    end

    // Depth store with clearing sweep
    logic [DEPTH_W-1:0] store_mem [STORE_N];
    logic [DEPTH_W-1:0] rd_reg;
    logic [ADDR_W-1:0]  clr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clear_write) begin
            clr_reg <= (clr_reg == LAST_A) ? '0 : clr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear_write) begin
            store_mem[clr_reg] <= DEPTH_FARTHEST;
        end else if (cmd.emit) begin
            store_mem[addr_reg] <= DEPTH_W'(depth);
        end
        if (cmd.mem_read) begin
            rd_reg <= store_mem[addr_reg];
        end
    end

    assign status.clear_last = (clr_reg == LAST_A);
    assign status.hit        = (DEPTH_W'(depth) < rd_reg);

    // Output register
    logic                  out_valid_reg;
    logic [M_TDATA_W-1:0]  out_data_reg;
    logic [15:0]           px_wide, py_wide;

    assign px_wide = 16'(px_reg);
    assign py_wide = 16'(py_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_data_reg <= {7'd0, color_reg, py_wide[PIX_Y_W-1:0], px_wide[PIX_X_W-1:0]};
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule

>>> rtl/core/perspective_dot_plotter_zbuffer.sv
// ============================================================================
// perspective_dot_plotter_zbuffer
// Rotates a 3D point by the camera pitch, projects it to a screen pixel and
// depth-tests it against a per-pixel depth store; passing points emit a pixel.
// ============================================================================
//
//  channel | direction | signals                              | content
//  --------+-----------+--------------------------------------+------------------
//  s_      | in        | s_tvalid s_tready s_tdata s_tuser    | point or clear
//  m_      | out       | m_tvalid m_tready m_tdata            | pixel write
//  cfg_    | in        | cfg_valid cfg_ready cfg_index cfg_data | register write
//
//  The time of a plot item is set by the one-bit-per-cycle divider, which
//  runs twice (column, then row), plus the shared multiplier steps. A clear
//  item, and reset, sweep the store at one entry per cycle with s_tready low.
//  A finished pixel waits in the output register; the next item is taken
//  meanwhile and stalls only when it must emit while that register is full.
//
module perspective_dot_plotter_zbuffer #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // side[15:0], forward[31:16], point_height[47:32], point_color[55:48]
    input  logic [pdz_pkg::S_TDATA_W-1:0]      s_tdata,
    // operation[0]
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // pixel_x[8:0], pixel_y[16:9], pixel_color[24:17], zero[31:25]
    output logic [pdz_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pdz_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pdz_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pdz_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    pdz_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pdz_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_tdata),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

>>> tb/perspective_dot_plotter_zbuffer_test.sv
`timescale 1ns / 100ps
// ============================================================================
// perspective_dot_plotter_zbuffer_test
// Drives 3D points and clear items into the perspective dot plotter, predicts
// each pixel write with its own projection and depth-store model, and checks
// every pixel write in order. Register settings change between phases.
// ============================================================================
import pdz_pkg::*;

// Pixel write predictor and checker
class pixel_scoreboard;
    localparam int SW = 320;
    localparam int SH = 200;

    logic signed [15:0] cos_p, sin_p, cam_h;
    logic [14:0]        near_p, far_p;
    logic [15:0]        zdepth [SW*SH];
    logic [24:0]        pending_pixels [$];
    int                 errors;
    int                 hits;
    int                 rejects;

    function new();
        cos_p  = COS_PITCH_RST;
        sin_p  = SIN_PITCH_RST;
        cam_h  = CAM_HEIGHT_RST;
        near_p = NEAR_PLANE_RST;
        far_p  = FAR_PLANE_RST;
        errors = 0;
        hits = 0;
        rejects = 0;
        wipe();
    endfunction

    function void wipe();
        foreach (zdepth[i]) zdepth[i] = DEPTH_FARTHEST;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
        case (idx)
            CFG_COS_PITCH:  cos_p  = val;
            CFG_SIN_PITCH:  sin_p  = val;
            CFG_CAM_HEIGHT: cam_h  = val;
            CFG_NEAR_PLANE: near_p = val[14:0];
            CFG_FAR_PLANE:  far_p  = val[14:0];
            default: ;
        endcase
    endfunction

    static function longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q--;
        return q;
    endfunction

    // Note an accepted item and queue the pixel write it causes, if any
    function void note_item(logic op, logic [55:0] d);
        longint s, f, h, up, dz, px, py;
        int idx;
        if (op == OP_CLEAR) begin
            wipe();
            return;
        end
        s = $signed(d[15:0]);
        f = $signed(d[31:16]);
        h = longint'($signed(d[47:32])) - longint'(cam_h);
        up = fdiv(h * cos_p - f * sin_p, 16384);
        dz = fdiv(h * sin_p + f * cos_p, 16384);
        if (dz <= 0 || dz < near_p || dz > far_p) begin
            rejects++;
            return;
        end
        px = fdiv(SW * (dz + s), 2 * dz);
        py = fdiv(SH * (dz - up), 2 * dz);
        if (px < 0 || px >= SW || py < 0 || py >= SH) begin
            rejects++;
            return;
        end
        idx = int'(py) * SW + int'(px);
        if (dz >= zdepth[idx]) begin
            rejects++;
            return;
        end
        zdepth[idx] = dz[15:0];
        pending_pixels.push_back({d[55:48], py[7:0], px[8:0]});
    endfunction

    // Compare one pixel write with the oldest expectation
    function void check_pixel(logic [31:0] got);
        logic [24:0] want;
        if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected pixel write %h", $time, got);
            errors++;
            return;
        end
        want = pending_pixels.pop_front();
        hits++;
        if (got[8:0] !== want[8:0]) begin
            $display("%0t: pixel_x expected %0d actual %0d", $time, want[8:0], got[8:0]);
            errors++;
        end
        if (got[16:9] !== want[16:9]) begin
            $display("%0t: pixel_y expected %0d actual %0d", $time, want[16:9], got[16:9]);
            errors++;
        end
        if (got[24:17] !== want[24:17]) begin
            $display("%0t: pixel_color expected %0d actual %0d", $time, want[24:17],
                     got[24:17]);
            errors++;
        end
        if (got[31:25] !== 7'd0) begin
            $display("%0t: pad bits expected 0 actual %h", $time, got[31:25]);
            errors++;
        end
    endfunction
endclass

module perspective_dot_plotter_zbuffer_test;
    localparam longint CYCLE_LIMIT = 64'd3_000_000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    pixel_scoreboard pixels;
    longint cycles;
    bit     quiet;     // no idling on either side
    int     clears;

    perspective_dot_plotter_zbuffer dut (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Sink with random stall
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) pixels.check_pixel(m_tdata);
        m_tready <= quiet || ($urandom_range(99) >= 9);
    end

    // Valid stays high after an accept when the next item follows at once
    task automatic send_item(logic op, logic [55:0] d);
        while (!quiet && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        pixels.note_item(op, d);
    endtask

    task automatic plot(int s, int f, int h, int c);
        send_item(OP_PLOT, {c[7:0], h[15:0], f[15:0], s[15:0]});
    endtask

    // Drop valid, drain results, then wait until the block is idle again
    task automatic settle();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (pixels.pending_pixels.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (200) @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        pixels.write_reg(idx, val);
    endtask

    task automatic set_camera(int c, int s, int h, int n, int f);
        settle();
        write_reg(CFG_COS_PITCH, c[15:0]);
        write_reg(CFG_SIN_PITCH, s[15:0]);
        write_reg(CFG_CAM_HEIGHT, h[15:0]);
        write_reg(CFG_NEAR_PLANE, n[15:0]);
        write_reg(CFG_FAR_PLANE, f[15:0]);
        cfg_valid <= 1'b0;
    endtask

    // Mostly points in front of the camera that land on screen
    task automatic random_points(int count);
        int s, f, h;
        repeat (count) begin
            case ($urandom_range(9))
                0: send_item(OP_PLOT, 56'({$urandom, $urandom}));
                1: begin
                    if ($urandom_range(19) == 0) begin
                        send_item(OP_CLEAR, 56'({$urandom, $urandom}));
                        clears++;
                    end else begin
                        plot($urandom_range(40) * 256 - 5120, $urandom_range(20) * 256,
                             $urandom_range(20) * 256 - 2560, $urandom);
                    end
                end
                default: begin
                    f = $urandom_range(12000, 512);
                    s = $urandom_range(f * 2) - f;
                    h = $urandom_range(16000) - 8000;
                    plot(s, f, h, $urandom);
                end
            endcase
        end
    endtask

    initial begin
        pixels    = new();
        quiet     = 1'b0;
        clears    = 0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, both operations, special cases
        plot(0, 2560, 5120, 8'h01);
        plot(0, 2560, 5120, 8'h02);            // tie in depth
        plot(0, 2000, 5120, 8'hFF);            // nearer wins
        plot(0, 3000, 5120, 8'h03);            // farther loses
        plot(-32768, -32768, -32768, 0);
        plot(32767, 32767, 32767, 8'hFF);
        plot(0, -2560, 5120, 8'h04);           // behind camera
        plot(0, 100, 5120, 8'h05);             // inside near plane
        plot(0, 32767, 5120, 8'h06);           // beyond far plane
        plot(20000, 2560, 5120, 8'h07);        // off screen
        send_item(OP_CLEAR, '0);
        send_item(OP_CLEAR, {56{1'b1}});
        plot(0, 2560, 5120, 8'h08);            // store cleared, passes again
        plot(-2559, 2560, 5120, 8'h09);        // off screen past the left edge
        plot(2559, 2560, 5120, 8'h0A);         // off screen past the right edge

        // Straight camera, near above far rejects all
        set_camera(16384, 0, 0, 5000, 1000);
        plot(0, 3000, 0, 8'h10);
        random_points(40);
        // Extremes of the registers, nonpositive depth with near at zero
        set_camera(-16384, 16384, -32768, 0, 32767);
        plot(0, 0, 0, 8'h11);
        random_points(40);
        set_camera(16384, -16384, 32767, 1, 1);
        random_points(40);
        set_camera(16384, 0, 0, 1, 32767);
        plot(0, 256, 0, 8'h12);
        plot(0, 1, 0, 8'h13);
        random_points(300);
        // Invalid index is ignored
        settle();
        write_reg(3'd7, 16'hFFFF);
        write_reg(3'd5, 16'h0000);
        cfg_valid <= 1'b0;

        // Main random phase at reset-like settings, with a stretch without idling
        set_camera(14378, -7855, 2000, 256, 25600);
        random_points(400);
        quiet = 1'b1;
        random_points(300);
        quiet = 1'b0;
        set_camera($urandom_range(16384, 12000), -$urandom_range(4000), 1000, 64, 20000);
        random_points(600);

        settle();
        $display("Checked %0d pixel writes; %0d points rejected; %0d random clears.",
                 pixels.hits, pixels.rejects, clears);
        if (pixels.errors == 0 && pixels.pending_pixels.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/core/pdz_pkg.sv
rtl/core/pdz_ctrl.sv
rtl/core/pdz_datapath.sv
rtl/core/perspective_dot_plotter_zbuffer.sv
tb/perspective_dot_plotter_zbuffer_test.sv
